### hdl/tcst_pkg.sv
// Shared types, constants and the flag/state transition function of the TCP
// connection state tracker.
// No dependencies; every other file of the block but tcst_ram imports this package.
package tcst_pkg;

   // Default number of flow slots in the state table.
   localparam int FLOW_ENTRIES_DEFAULT = 1024;

   // Input, output and state field widths.
   localparam int FLOW_INDEX_W = 10;
   localparam int FLAGS_W      = 8;
   localparam int SEQ_W        = 32;
   localparam int WIN_IN_W     = 16;
   localparam int SHIFT_W      = 4;
   localparam int VERDICT_W    = 2;
   localparam int TSTATE_W     = 4;

   // Configuration port.
   localparam int CSR_ADDR_W   = 3;
   localparam int CSR_DATA_W   = 32;
   localparam logic CSR_IDX_WINDOW_SCALE = 1'b0;
   localparam logic [SHIFT_W-1:0] SHIFT_RESET = 4'd10;

   // TCP flag bits.
   localparam logic [FLAGS_W-1:0] F_FIN = 8'h01;
   localparam logic [FLAGS_W-1:0] F_SYN = 8'h02;
   localparam logic [FLAGS_W-1:0] F_RST = 8'h04;
   localparam logic [FLAGS_W-1:0] F_ACK = 8'h10;
   localparam int RST_BIT = 2;
   localparam int SYN_BIT = 1;

   // Per-endpoint TCP state codes.
   localparam logic [TSTATE_W-1:0] S_EST     = 4'd1;
   localparam logic [TSTATE_W-1:0] S_SYNSENT = 4'd2;
   localparam logic [TSTATE_W-1:0] S_SYNRECV = 4'd3;
   localparam logic [TSTATE_W-1:0] S_FW1     = 4'd4;
   localparam logic [TSTATE_W-1:0] S_FW2     = 4'd5;
   localparam logic [TSTATE_W-1:0] S_TW      = 4'd6;
   localparam logic [TSTATE_W-1:0] S_CLOSED  = 4'd7;
   localparam logic [TSTATE_W-1:0] S_CW      = 4'd8;
   localparam logic [TSTATE_W-1:0] S_LASTACK = 4'd9;
   localparam logic [TSTATE_W-1:0] S_CLOSING = 4'd11;

   // Verdict codes.
   localparam logic [VERDICT_W-1:0] V_REFUSED = 2'd0;
   localparam logic [VERDICT_W-1:0] V_OUT_WIN = 2'd1;
   localparam logic [VERDICT_W-1:0] V_ACCEPT  = 2'd2;
   localparam logic [VERDICT_W-1:0] V_STALE   = 2'd3;

   // Reciprocal used to reduce the flow index modulo the table depth.
   localparam int RECIP_SHIFT = 20;
   localparam int PROD_W      = 30;
   localparam int REM_W       = 27;

   // One table entry: both endpoint states, sequences and windows.
   typedef struct packed {
      logic [TSTATE_W-1:0] lst;
      logic [TSTATE_W-1:0] ust;
      logic [SEQ_W-1:0]    lseq;
      logic [SEQ_W-1:0]    useq;
      logic [SEQ_W-1:0]    lwin;
      logic [SEQ_W-1:0]    uwin;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   // Outcome of the flag check.
   typedef struct packed {
      logic                ok;
      logic                chal;
      logic [TSTATE_W-1:0] fs;
      logic [TSTATE_W-1:0] fr;
   } nxt_type;

   // Controller states.
   typedef enum logic [2:0] {
      ST_CLEAR, ST_IDLE, ST_QUOT, ST_ADDR, ST_CALC, ST_DECIDE, ST_RESP
   } ctrl_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic clr_step;
      logic capture;
      logic quot_en;
      logic addr_en;
      logic calc_en;
      logic decide_en;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic clr_last;
   } sts_type;

   // Checks the flags against the sender's state and gives the next states.
   function automatic nxt_type next_states(input logic [TSTATE_W-1:0] snd,
                                           input logic [TSTATE_W-1:0] rec,
                                           input logic [FLAGS_W-1:0] raw);
      nxt_type r;
      logic [FLAGS_W-1:0] fl;
      logic closing;
      r = '0;
      closing = 1'b0;
      fl = raw & (F_ACK | F_FIN | F_SYN | F_RST);
      case (snd)
         S_EST: begin
            if (fl == F_ACK) begin
               r.ok = 1'b1; r.fs = S_EST; r.fr = S_EST;
            end else if (fl == (F_FIN | F_ACK)) begin
               r.ok = 1'b1; r.fs = S_FW1; r.fr = S_CW;
            end else if (fl == (F_ACK | F_RST)) begin
               r.ok = 1'b1; r.fs = S_CLOSED; r.fr = S_CLOSED;
            end
         end
         S_CLOSED: begin
            if (fl == F_SYN) begin
               r.ok = 1'b1; r.fs = S_SYNSENT; r.fr = S_SYNRECV;
            end
         end
         S_SYNRECV: begin
            if (fl == (F_SYN | F_ACK)) begin
               r.ok = 1'b1; r.fs = S_SYNRECV; r.fr = S_EST;
            end else if (fl == F_SYN) begin
               r.ok = 1'b1; r.fs = S_SYNRECV; r.fr = S_SYNRECV;
            end else if (fl == (F_FIN | F_ACK)) begin
               r.ok = 1'b1; r.fs = S_FW1; r.fr = S_CW;
            end else if (fl == (F_ACK | F_RST)) begin
               r.ok = 1'b1; r.fs = S_CLOSED; r.fr = S_CLOSED;
            end
         end
         S_CW: begin
            if (fl == F_ACK) begin
               r.ok = 1'b1; r.fs = S_CW; r.fr = S_FW2; r.chal = 1'b1;
            end else if (fl == (F_FIN | F_ACK)) begin
               r.ok = 1'b1;
               if (rec == S_FW1) begin
                  r.fs = S_CLOSING; r.fr = S_CLOSING;
               end else begin
                  r.fs = S_LASTACK; r.fr = S_TW;
               end
            end else if (fl == (F_ACK | F_RST)) begin
               r.ok = 1'b1; r.fs = S_CLOSED; r.fr = S_CLOSED;
            end
         end
         S_FW1, S_FW2: begin
            if (fl == F_ACK) begin
               r.ok = 1'b1; r.fs = snd; r.fr = rec;
            end else begin
               closing = 1'b1;
            end
         end
         S_TW: begin
            if (fl == F_ACK) begin
               r.ok = 1'b1; r.fs = S_CLOSED; r.fr = S_CLOSED;
            end else begin
               closing = 1'b1;
            end
         end
         S_CLOSING: begin
            closing = 1'b1;
         end
         default: begin
            r.ok = 1'b0;
         end
      endcase
      // Closing check tests the raw ACK, FIN and SYN bits.
      if (closing && ((raw & (F_ACK | F_FIN | F_SYN)) == F_ACK)) begin
         r.ok = 1'b1;
         r.fs = S_CLOSED;
         r.fr = raw[RST_BIT] ? S_CLOSED : rec;
      end
      return r;
   endfunction

endpackage

### hdl/tcst_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module tcst_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

### hdl/tcst_ctrl.sv
// Controller state machine of the TCP connection state tracker.
// Depends on tcst_pkg for the state, command and status types.
module tcst_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   input  tcst_pkg::sts_type sts,
   output tcst_pkg::cmd_type cmd
);
   import tcst_pkg::*;

   ctrl_state_type state_ff, state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (sts.clr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in = ST_QUOT;
            end
         end
         ST_QUOT: begin
            cmd.quot_en = 1'b1;
            state_in = ST_ADDR;
         end
         ST_ADDR: begin
            cmd.addr_en = 1'b1;
            state_in = ST_CALC;
         end
         ST_CALC: begin
            cmd.calc_en = 1'b1;
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            cmd.decide_en = 1'b1;
            state_in = ST_RESP;
         end
         ST_RESP: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end
endmodule

### hdl/tcst_datapath.sv
// Datapath of the TCP connection state tracker: input registers, slot
// reduction, flow table, checks and write-back. Depends on tcst_pkg, tcst_ram.
module tcst_datapath #(
   parameter int FLOW_ENTRIES = tcst_pkg::FLOW_ENTRIES_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  tcst_pkg::cmd_type                      cmd,
   output tcst_pkg::sts_type                      sts,
   input  logic [tcst_pkg::SHIFT_W-1:0]           scale_shift,
   input  logic [tcst_pkg::FLOW_INDEX_W-1:0]      req_flow_index,
   input  logic                                   req_sender_is_lower,
   input  logic [tcst_pkg::FLAGS_W-1:0]           req_tcp_flags,
   input  logic [tcst_pkg::SEQ_W-1:0]             req_sequence_number,
   input  logic [tcst_pkg::SEQ_W-1:0]             req_ack_number,
   input  logic [tcst_pkg::WIN_IN_W-1:0]          req_advertised_window,
   output logic [tcst_pkg::VERDICT_W-1:0]         rsp_verdict,
   output logic                                   rsp_pass_segment
);
   import tcst_pkg::*;

   localparam int IDX_W = $clog2(FLOW_ENTRIES);
   localparam int RECIP = (1 << RECIP_SHIFT) / FLOW_ENTRIES;

   // Captured transaction.
   logic [FLOW_INDEX_W-1:0] idx_ff;
   logic                    lower_ff;
   logic [FLAGS_W-1:0]      flags_ff;
   logic [SEQ_W-1:0]        seq_ff;
   logic [SEQ_W-1:0]        ack_ff;
   logic [WIN_IN_W-1:0]     win_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         idx_ff   <= req_flow_index;
         lower_ff <= req_sender_is_lower;
         flags_ff <= req_tcp_flags;
         seq_ff   <= req_sequence_number;
         ack_ff   <= req_ack_number;
         win_ff   <= req_advertised_window;
      end
   end

   // Quotient estimate by reciprocal multiplication; at most one short.
   logic [PROD_W-1:0]       prod;
   logic [FLOW_INDEX_W-1:0] quot_ff;
   assign prod = PROD_W'(idx_ff) * PROD_W'(RECIP);

   always_ff @(posedge clock) begin
      if (cmd.quot_en) begin
         quot_ff <= prod[RECIP_SHIFT +: FLOW_INDEX_W];
      end
   end

   // Remainder with a single correction gives the slot.
   logic [REM_W-1:0] qn, rem0, rem1;
   logic [IDX_W-1:0] slot, slot_ff;
   assign qn   = REM_W'(quot_ff) * REM_W'(FLOW_ENTRIES);
   assign rem0 = REM_W'(idx_ff) - qn;
   assign rem1 = (rem0 >= REM_W'(FLOW_ENTRIES)) ? rem0 - REM_W'(FLOW_ENTRIES) : rem0;
   assign slot = rem1[IDX_W-1:0];

   always_ff @(posedge clock) begin
      if (cmd.addr_en) begin
         slot_ff <= slot;
      end
   end

   // Clearing pass counter after reset.
   logic [IDX_W-1:0] clr_cnt_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
      end else if (cmd.clr_step) begin
         clr_cnt_ff <= clr_cnt_ff + 1'b1;
      end
   end
   assign sts.clr_last = (clr_cnt_ff == IDX_W'(FLOW_ENTRIES - 1));

   // Flow table.
   entry_type rd_data, wr_entry, reset_entry;
   logic      wr_en;
   logic      upd_en;
   logic [IDX_W-1:0] wr_addr;
   logic [ENTRY_W-1:0] wr_data;

   always_comb begin
      reset_entry = '0;
      reset_entry.lst = S_CLOSED;
      reset_entry.ust = S_CLOSED;
   end

   assign wr_en   = cmd.clr_step | upd_en;
   assign wr_addr = cmd.clr_step ? clr_cnt_ff : slot_ff;
   assign wr_data = cmd.clr_step ? reset_entry : wr_entry;

   tcst_ram #(
      .WIDTH(ENTRY_W),
      .DEPTH(FLOW_ENTRIES)
   ) u_table (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(slot),
      .rd_data(rd_data)
   );

   // Flag check and window bound, registered.
   entry_type        ent_ff;
   nxt_type          nxt_ff;
   logic [SEQ_W-1:0] limit_ff;
   logic [TSTATE_W-1:0] snd, rec;
   logic [SEQ_W-1:0] sseq_rd, swin_rd;

   assign snd     = lower_ff ? rd_data.lst : rd_data.ust;
   assign rec     = lower_ff ? rd_data.ust : rd_data.lst;
   assign sseq_rd = lower_ff ? rd_data.lseq : rd_data.useq;
   assign swin_rd = lower_ff ? rd_data.lwin : rd_data.uwin;

   always_ff @(posedge clock) begin
      if (cmd.calc_en) begin
         ent_ff   <= rd_data;
         nxt_ff   <= next_states(snd, rec, flags_ff);
         limit_ff <= sseq_rd + swin_rd;
      end
   end

   // Decision and write-back.
   logic [SEQ_W-1:0] sseq, d_lo, d_hi, d_ack, d_seq, scaled;
   logic             oow, stale, close_hit;
   logic [TSTATE_W-1:0] fs_fin;
   logic [VERDICT_W-1:0] verdict;

   assign sseq  = lower_ff ? ent_ff.lseq : ent_ff.useq;
   assign d_lo  = seq_ff - sseq;
   assign d_hi  = seq_ff - limit_ff;
   assign d_ack = ack_ff - (lower_ff ? ent_ff.useq : ent_ff.lseq);
   assign d_seq = seq_ff - ent_ff.lseq;
   assign oow   = (d_lo[SEQ_W-1] || !d_hi[SEQ_W-1]) && !flags_ff[SYN_BIT];
   assign stale = nxt_ff.chal && d_ack[SEQ_W-1] && d_seq[SEQ_W-1];
   assign scaled = SEQ_W'({16'd0, win_ff} << scale_shift);

   always_comb begin
      close_hit = lower_ff ? (ack_ff == ent_ff.useq) : (ack_ff > ent_ff.lseq);
      fs_fin = (nxt_ff.fs == S_CLOSING && nxt_ff.fr == S_CLOSING && close_hit)
               ? S_CLOSED : nxt_ff.fs;
      wr_entry = ent_ff;
      if (lower_ff) begin
         wr_entry.useq = ack_ff;
         wr_entry.uwin = scaled;
         wr_entry.lst  = fs_fin;
         wr_entry.ust  = nxt_ff.fr;
      end else begin
         wr_entry.lseq = ack_ff;
         wr_entry.lwin = scaled;
         wr_entry.ust  = fs_fin;
         wr_entry.lst  = nxt_ff.fr;
      end
      if (flags_ff[RST_BIT] || (fs_fin == S_CLOSED && nxt_ff.fr == S_CLOSED)) begin
         wr_entry.lseq = '0;
         wr_entry.useq = '0;
      end
      if (!nxt_ff.ok) begin
         verdict = V_REFUSED;
      end else if (oow) begin
         verdict = V_OUT_WIN;
      end else if (stale) begin
         verdict = V_STALE;
      end else begin
         verdict = V_ACCEPT;
      end
   end

   assign upd_en = cmd.decide_en && (verdict == V_ACCEPT);

   // Result register.
   always_ff @(posedge clock) begin
      if (cmd.decide_en) begin
         rsp_verdict      <= verdict;
         rsp_pass_segment <= (verdict == V_ACCEPT) || (verdict == V_STALE);
      end
   end
endmodule

### hdl/tcp_connection_state_tracker.sv
// TCP connection state tracker: per-flow TCP state checking of segment
// summaries, one verdict per segment.
// Usage:
//   The req_ channel carries one segment summary per transaction (flow slot,
//   sender side, flags, sequence, acknowledgement, window). The rsp_ channel
//   returns one verdict and a pass flag per segment, in order.
//   The csr_ port is an APB-style port holding the window scale shift at
//   byte address 0; pready is always high.
// Processing:
//   One segment is processed at a time. After the accepting edge it passes
//   the quotient, table address, table read and flag check, and decision and
//   write-back steps, each registered, before rsp_valid rises. The next segment
//   is taken only after the result transaction, once the block is idle again.
//   This is set by the read-modify-write of the single flow table port pair.
// Reset:
//   Synchronous reset starts a clearing pass that writes every slot to
//   closed/zero; req_ready stays low during it, while configuration writes
//   are taken. The shift resets to 10.
// Stalls:
//   While rsp_ready is low the verdict is held and no new segment is taken.
module tcp_connection_state_tracker #(
   parameter int FLOW_ENTRIES = tcst_pkg::FLOW_ENTRIES_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [tcst_pkg::FLOW_INDEX_W-1:0]   req_flow_index,
   input  logic                                req_sender_is_lower,
   input  logic [tcst_pkg::FLAGS_W-1:0]        req_tcp_flags,
   input  logic [tcst_pkg::SEQ_W-1:0]          req_sequence_number,
   input  logic [tcst_pkg::SEQ_W-1:0]          req_ack_number,
   input  logic [tcst_pkg::WIN_IN_W-1:0]       req_advertised_window,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [tcst_pkg::VERDICT_W-1:0]      rsp_verdict,
   output logic                                rsp_pass_segment,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [tcst_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [tcst_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [tcst_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);
   import tcst_pkg::*;

   cmd_type cmd;
   sts_type sts;
   logic [SHIFT_W-1:0] shift_ff;
   logic               csr_sel_shift;

   // Configuration register.
   assign csr_pready    = 1'b1;
   assign csr_sel_shift = (csr_paddr[2] == CSR_IDX_WINDOW_SCALE);

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff <= SHIFT_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_sel_shift) begin
         shift_ff <= csr_pwdata[SHIFT_W-1:0];
      end
   end

   assign csr_prdata = csr_sel_shift ? CSR_DATA_W'(shift_ff) : '0;

   tcst_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .sts      (sts),
      .cmd      (cmd)
   );

   tcst_datapath #(
      .FLOW_ENTRIES(FLOW_ENTRIES)
   ) u_datapath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .sts                  (sts),
      .scale_shift          (shift_ff),
      .req_flow_index       (req_flow_index),
      .req_sender_is_lower  (req_sender_is_lower),
      .req_tcp_flags        (req_tcp_flags),
      .req_sequence_number  (req_sequence_number),
      .req_ack_number       (req_ack_number),
      .req_advertised_window(req_advertised_window),
      .rsp_verdict          (rsp_verdict),
      .rsp_pass_segment     (rsp_pass_segment)
   );

`ifndef SYNTH
   // Only one segment is in flight: no new transaction while a verdict waits.
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("input taken while a verdict is pending");

   // The pass flag agrees with the verdict.
   a_pass_matches: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_pass_segment ==
                     ((rsp_verdict == V_ACCEPT) || (rsp_verdict == V_STALE))))
      else $error("pass flag disagrees with verdict");

   // The clearing pass keeps the input closed right after reset.
   a_clear_after_reset: assert property (@(posedge clock)
      $fell(reset) |-> !req_ready)
      else $error("input open during clearing pass");
`endif
endmodule

### test/tb_tcp_connection_state_tracker.sv
// Self-checking testbench for the TCP connection state tracker.
// Depends on hdl/tcst_pkg.sv and hdl/tcp_connection_state_tracker.sv; a scoreboard
// class predicts each verdict from its own copy of the flow table.
`timescale 1ns / 1ps

module tb_tcp_connection_state_tracker;
   import tcst_pkg::*;

   localparam int FLOWS       = FLOW_ENTRIES_DEFAULT;
   localparam int STALL_LIMIT = 5000;
   localparam int HOLD_CYCLES = 300;
   localparam logic [CSR_ADDR_W-1:0] ADDR_WINDOW_SCALE = {CSR_IDX_WINDOW_SCALE, 2'b00};

   typedef struct {
      logic [VERDICT_W-1:0] verdict;
      logic                 pass_seg;
   } verdict_type;

   // Scoreboard: a copy of the flow table, the shift and the verdicts still owed.
   class verdict_scoreboard;
      logic [TSTATE_W-1:0] lst [FLOWS];
      logic [TSTATE_W-1:0] ust [FLOWS];
      logic [SEQ_W-1:0]    lseq [FLOWS];
      logic [SEQ_W-1:0]    useq [FLOWS];
      logic [SEQ_W-1:0]    lwin [FLOWS];
      logic [SEQ_W-1:0]    uwin [FLOWS];
      logic [SHIFT_W-1:0]  shift;
      verdict_type         owed [$];
      int                  errors;

      function new();
         for (int i = 0; i < FLOWS; i++) begin
            lst[i] = S_CLOSED; ust[i] = S_CLOSED;
            lseq[i] = '0; useq[i] = '0; lwin[i] = '0; uwin[i] = '0;
         end
         shift = SHIFT_RESET;
         errors = 0;
      endfunction

      function bit precedes(logic [SEQ_W-1:0] a, logic [SEQ_W-1:0] b);
         logic [SEQ_W-1:0] d;
         d = a - b;
         return d[SEQ_W-1];
      endfunction

      // Notes an accepted segment and works out its verdict.
      function void note(int slot, bit lower, logic [FLAGS_W-1:0] raw,
                         logic [SEQ_W-1:0] seq, logic [SEQ_W-1:0] ack,
                         logic [WIN_IN_W-1:0] win);
         logic [TSTATE_W-1:0] snd, rec, fs, fr;
         logic [FLAGS_W-1:0]  fl;
         logic [SEQ_W-1:0]    sseq, swin, scaled;
         bit ok, chal, closing;
         verdict_type v;
         snd = lower ? lst[slot] : ust[slot];
         rec = lower ? ust[slot] : lst[slot];
         fl = raw & (F_ACK | F_FIN | F_SYN | F_RST);
         ok = 0; chal = 0; closing = 0; fs = '0; fr = '0;
         scaled = {16'h0, win} << shift;
         case (snd)
            S_EST: begin
               if (fl == F_ACK) begin ok = 1; fs = S_EST; fr = S_EST; end
               else if (fl == (F_FIN | F_ACK)) begin ok = 1; fs = S_FW1; fr = S_CW; end
               else if (fl == (F_ACK | F_RST)) begin ok = 1; fs = S_CLOSED; fr = S_CLOSED; end
            end
            S_CLOSED: begin
               if (fl == F_SYN) begin ok = 1; fs = S_SYNSENT; fr = S_SYNRECV; end
            end
            S_SYNRECV: begin
               if (fl == (F_SYN | F_ACK)) begin ok = 1; fs = S_SYNRECV; fr = S_EST; end
               else if (fl == F_SYN) begin ok = 1; fs = S_SYNRECV; fr = S_SYNRECV; end
               else if (fl == (F_FIN | F_ACK)) begin ok = 1; fs = S_FW1; fr = S_CW; end
               else if (fl == (F_ACK | F_RST)) begin ok = 1; fs = S_CLOSED; fr = S_CLOSED; end
            end
            S_CW: begin
               if (fl == F_ACK) begin ok = 1; chal = 1; fs = S_CW; fr = S_FW2; end
               else if (fl == (F_FIN | F_ACK)) begin
                  ok = 1;
                  fs = (rec == S_FW1) ? S_CLOSING : S_LASTACK;
                  fr = (rec == S_FW1) ? S_CLOSING : S_TW;
               end
               else if (fl == (F_ACK | F_RST)) begin ok = 1; fs = S_CLOSED; fr = S_CLOSED; end
            end
            S_FW1, S_FW2: begin
               if (fl == F_ACK) begin ok = 1; fs = snd; fr = rec; end
               else closing = 1;
            end
            S_TW: begin
               if (fl == F_ACK) begin ok = 1; fs = S_CLOSED; fr = S_CLOSED; end
               else closing = 1;
            end
            S_CLOSING: closing = 1;
            default: ok = 0;
         endcase
         // The closing check falls through from fin-wait, time-wait and closing on raw bits.
         if (closing && ((raw & (F_ACK | F_FIN | F_SYN)) == F_ACK)) begin
            ok = 1; fs = S_CLOSED;
            fr = raw[RST_BIT] ? S_CLOSED : rec;
         end
         v.verdict = V_ACCEPT; v.pass_seg = 1'b1;
         sseq = lower ? lseq[slot] : useq[slot];
         swin = lower ? lwin[slot] : uwin[slot];
         if (!ok) begin
            v.verdict = V_REFUSED; v.pass_seg = 1'b0;
         end else if ((precedes(seq, sseq) || !precedes(seq, sseq + swin)) && !raw[SYN_BIT]) begin
            v.verdict = V_OUT_WIN; v.pass_seg = 1'b0;
         end else if (chal && precedes(ack, lower ? useq[slot] : lseq[slot])
                      && precedes(seq, lseq[slot])) begin
            v.verdict = V_STALE;
         end else begin
            if (lower) begin
               if (fs == S_CLOSING && fr == S_CLOSING && ack == useq[slot]) fs = S_CLOSED;
               useq[slot] = ack; uwin[slot] = scaled;
               lst[slot] = fs; ust[slot] = fr;
            end else begin
               if (fs == S_CLOSING && fr == S_CLOSING && ack > lseq[slot]) fs = S_CLOSED;
               lseq[slot] = ack; lwin[slot] = scaled;
               ust[slot] = fs; lst[slot] = fr;
            end
            if (raw[RST_BIT] || (fs == S_CLOSED && fr == S_CLOSED)) begin
               lseq[slot] = '0; useq[slot] = '0;
            end
         end
         owed.push_back(v);
      endfunction

      // Compares a returned verdict with the oldest one owed.
      function void check(logic [VERDICT_W-1:0] verdict, logic pass_seg);
         verdict_type v;
         if (owed.size() == 0) begin
            $display("%0t: unexpected verdict %0d pass %0d", $time, verdict, pass_seg);
            errors++;
            return;
         end
         v = owed.pop_front();
         if (verdict !== v.verdict) begin
            $display("%0t: verdict expected %0d actual %0d", $time, v.verdict, verdict);
            errors++;
         end
         if (pass_seg !== v.pass_seg) begin
            $display("%0t: pass_segment expected %0d actual %0d", $time, v.pass_seg, pass_seg);
            errors++;
         end
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [FLOW_INDEX_W-1:0] req_flow_index = '0;
   logic                  req_sender_is_lower = 1'b0;
   logic [FLAGS_W-1:0]    req_tcp_flags = '0;
   logic [SEQ_W-1:0]      req_sequence_number = '0;
   logic [SEQ_W-1:0]      req_ack_number = '0;
   logic [WIN_IN_W-1:0]   req_advertised_window = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [VERDICT_W-1:0]  rsp_verdict;
   logic                  rsp_pass_segment;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   verdict_scoreboard sb = new();
   int send_idle = 0;
   int recv_idle = 0;
   bit hold_request = 0;
   int hold_left = 0;
   int quiet_cycles = 0;

   tcp_connection_state_tracker i_dut (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Receiver: random back-pressure, plus one long hold-off when asked.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_request && hold_left == 0) begin
         hold_request = 0;
         hold_left = HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= recv_idle);
      end
   end

   // Result monitor and watchdog on cycles without any transaction.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) sb.check(rsp_verdict, rsp_pass_segment);
         if ((rsp_valid && rsp_ready) || (req_valid && req_ready)) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   // Offers one segment and waits for its transaction; valid stays high afterwards.
   task automatic send(int slot, bit lower, logic [FLAGS_W-1:0] flags,
                       logic [SEQ_W-1:0] seq, logic [SEQ_W-1:0] ack,
                       logic [WIN_IN_W-1:0] win);
      int gap;
      gap = 0;
      while ($urandom_range(0, 99) < send_idle) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_flow_index <= FLOW_INDEX_W'(slot);
      req_sender_is_lower <= lower;
      req_tcp_flags <= flags;
      req_sequence_number <= seq;
      req_ack_number <= ack;
      req_advertised_window <= win;
      do @(posedge clock); while (!req_ready);
      sb.note(slot, lower, flags, seq, ack, win);
   endtask

   // Stops offering and waits until every verdict has returned and the block is quiet.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.owed.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   task automatic write_shift(logic [SHIFT_W-1:0] value);
      csr_psel <= 1'b1; csr_pwrite <= 1'b1; csr_penable <= 1'b0;
      csr_paddr <= ADDR_WINDOW_SCALE; csr_pwdata <= CSR_DATA_W'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      sb.shift = value;
      csr_psel <= 1'b0; csr_penable <= 1'b0; csr_pwrite <= 1'b0;
   endtask

   // Builds a segment that mostly follows the flow's current state.
   task automatic send_random();
      int slot;
      bit lower;
      logic [TSTATE_W-1:0] snd;
      logic [FLAGS_W-1:0] flags;
      logic [SEQ_W-1:0] seq, ack, sseq, swin;
      logic [WIN_IN_W-1:0] win;
      slot = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 15) : $urandom_range(0, FLOWS - 1);
      lower = 1'($urandom_range(0, 1));
      snd = lower ? sb.lst[slot] : sb.ust[slot];
      sseq = lower ? sb.lseq[slot] : sb.useq[slot];
      swin = lower ? sb.lwin[slot] : sb.uwin[slot];
      case (snd)
         S_CLOSED:  flags = ($urandom_range(0, 3) != 0) ? F_SYN : F_ACK;
         S_SYNRECV:
            case ($urandom_range(0, 3))
               0: flags = F_SYN | F_ACK;
               1: flags = F_SYN;
               2: flags = F_FIN | F_ACK;
               default: flags = F_ACK | F_RST;
            endcase
         S_EST, S_CW:
            case ($urandom_range(0, 5))
               0, 1, 2: flags = F_ACK;
               3, 4: flags = F_FIN | F_ACK;
               default: flags = F_ACK | F_RST;
            endcase
         default:
            case ($urandom_range(0, 3))
               0: flags = F_ACK;
               1: flags = F_ACK | F_RST;
               2: flags = F_ACK | F_FIN;
               default: flags = F_SYN | F_ACK;
            endcase
      endcase
      // Bits that the flag match ignores, and occasional noise.
      if ($urandom_range(0, 9) < 3) flags = flags | FLAGS_W'($urandom & 8'hE8);
      if ($urandom_range(0, 99) < 12) flags = FLAGS_W'($urandom);
      if (swin != 0 && $urandom_range(0, 99) < 85)
         seq = sseq + $urandom_range(0, (swin > 32'd4096) ? 32'd4096 : swin - 1);
      else if ($urandom_range(0, 1))
         seq = sseq - $urandom_range(1, 64);
      else
         seq = $urandom;
      case ($urandom_range(0, 4))
         0: ack = $urandom;
         1: ack = sb.lseq[slot] - $urandom_range(1, 64);
         2: ack = sb.useq[slot];
         3: ack = sb.lseq[slot] + $urandom_range(0, 64);
         default: ack = sb.useq[slot] + $urandom_range(0, 5000);
      endcase
      case ($urandom_range(0, 9))
         0: win = '0;
         1: win = '1;
         default: win = WIN_IN_W'($urandom);
      endcase
      send(slot, lower, flags, seq, ack, win);
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed: full handshake and teardown through time-wait to closed on the top slot.
      send(1023, 1, F_SYN, 32'hFFFF_FFF0, 32'h0000_1000, 16'hFFFF);
      send(1023, 1, F_ACK, 32'h0, 32'h0, 16'h0);
      send(1023, 0, F_SYN | F_ACK, 32'h0000_1000, 32'hFFFF_FFF8, 16'hFFFF);
      send(1023, 1, F_ACK | 8'h08, 32'hFFFF_FFFC, 32'h0000_1000, 16'h0000);
      send(1023, 0, F_ACK, 32'h0000_1000, 32'h0, 16'h1);
      send(1023, 1, F_ACK, 32'hFFFF_FFF0, 32'h0, 16'h1);
      send(1023, 1, F_FIN | F_ACK, 32'h0000_0004, 32'h0000_1000, 16'h0001);
      send(1023, 0, F_ACK, 32'h0000_1000, 32'h0000_8000, 16'h0010);
      send(1023, 0, F_ACK, 32'h0000_1001, 32'h0000_7FFF, 16'hFFFF);
      send(1023, 0, F_FIN | F_ACK | 8'hE0, 32'h0000_1002, 32'h0000_9000, 16'h0100);
      send(1023, 0, F_ACK, 32'h0000_1002, 32'h0, 16'h0);
      send(1023, 1, F_ACK, 32'h0000_9001, 32'hFFFF_FFFF, 16'h0);
      send(1023, 1, 8'h00, 32'h0, 32'h0, 16'h0);
      send(1023, 1, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
      // Simultaneous close, settled by the closing check with reset set.
      send(5, 1, F_SYN, 32'd100, 32'd500, 16'd10);
      send(5, 0, F_SYN | F_ACK, 32'd500, 32'd200, 16'd10);
      send(5, 1, F_FIN | F_ACK, 32'd200, 32'd500, 16'd10);
      send(5, 0, F_FIN | F_ACK, 32'd500, 32'd300, 16'd10);
      send(5, 1, F_ACK | F_RST, 32'd300, 32'd0, 16'd10);
      // Both ends in syn-recv, then reset from there.
      send(6, 1, F_SYN, 32'd0, 32'd7, 16'd1);
      send(6, 0, F_SYN, 32'd7, 32'd9, 16'd1);
      send(6, 1, F_ACK | F_RST, 32'd9, 32'd0, 16'd1);
      drain();

      // Random phases, each with its own shift and an idling pattern; the first and last share theirs.
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin write_shift(4'd0);  send_idle = 33; recv_idle = 57; end
            1: begin write_shift(4'd14); send_idle = 57; recv_idle = 33; end
            2: begin write_shift(4'd15); send_idle = 0;  recv_idle = 0;  end
            default: begin write_shift(4'd7); send_idle = 33; recv_idle = 57; end
         endcase
         for (int n = 0; n < 440; n++) begin
            if (ph == 2 && n == 100) hold_request = 1;
            send_random();
         end
         drain();
      end

      if (sb.errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

### sim.f
hdl/tcst_pkg.sv
hdl/tcst_ram.sv
hdl/tcst_ctrl.sv
hdl/tcst_datapath.sv
hdl/tcp_connection_state_tracker.sv
test/tb_tcp_connection_state_tracker.sv
